// ===== rtl/gakts_pkg.sv =====
// Shared types and constants for the two-state angle and gyro-bias filter.
package gakts_pkg;

   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   localparam logic [1:0] REG_MEAS_NOISE  = 2'd0;
   localparam logic [1:0] REG_ANGLE_NOISE = 2'd1;
   localparam logic [1:0] REG_BIAS_NOISE  = 2'd2;

   // One datapath micro-operation per controller step.
   typedef enum logic [4:0] {
      OP_NONE  = 5'd0,
      OP_MUL   = 5'd1,
      OP_ADD   = 5'd2,
      OP_SUB   = 5'd3,
      OP_DIV   = 5'd4
   } op_type;

   // Register file addresses inside the datapath.
   typedef enum logic [4:0] {
      R_ANGLE = 5'd0,  R_BIAS = 5'd1,  R_CAA = 5'd2,  R_CAB = 5'd3,
      R_CBA = 5'd4,    R_CBB = 5'd5,   R_RATE = 5'd6, R_MEAS = 5'd7,
      R_DT = 5'd8,     R_RN = 5'd9,    R_QA = 5'd10,  R_QB = 5'd11,
      R_ONE = 5'd12,   R_ZERO = 5'd13, R_T0 = 5'd14,  R_T1 = 5'd15,
      R_INNOV = 5'd16, R_COV = 5'd17,  R_K0 = 5'd18,  R_K1 = 5'd19,
      R_OMK = 5'd20,   R_KMO = 5'd21,  R_N00 = 5'd22, R_N01 = 5'd23,
      R_N10 = 5'd24,   R_N11 = 5'd25,  R_T2 = 5'd26
   } reg_type;

   typedef struct packed {
      op_type  op;
      reg_type src_a;
      reg_type src_b;
      reg_type dst;
   } uop_type;

   typedef struct packed {
      logic    start;   // begin an operation this cycle
      uop_type uop;
      logic    load_in; // capture input word
      logic    commit;  // copy new covariances into state
      logic    skip_k;  // covariance not positive: zero the gains
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic cov_pos;
   } sts_type;

   function automatic uop_type uop_rom(input logic [4:0] pc);
      uop_type u;
      u = '{OP_NONE, R_ZERO, R_ZERO, R_ZERO};
      case (pc)
         5'd0:  u = '{OP_SUB, R_RATE, R_BIAS, R_T0};
         5'd1:  u = '{OP_MUL, R_DT, R_T0, R_T0};
         5'd2:  u = '{OP_ADD, R_ANGLE, R_T0, R_ANGLE};
         5'd3:  u = '{OP_SUB, R_MEAS, R_ANGLE, R_INNOV};
         5'd4:  u = '{OP_ADD, R_CAA, R_RN, R_COV};
         5'd5:  u = '{OP_MUL, R_DT, R_CBA, R_T0};
         5'd6:  u = '{OP_SUB, R_CAA, R_T0, R_T0};
         5'd7:  u = '{OP_DIV, R_T0, R_COV, R_K0};
         5'd8:  u = '{OP_DIV, R_CBA, R_COV, R_K1};
         5'd9:  u = '{OP_MUL, R_K0, R_INNOV, R_T0};
         5'd10: u = '{OP_ADD, R_ANGLE, R_T0, R_ANGLE};
         5'd11: u = '{OP_MUL, R_K1, R_INNOV, R_T0};
         5'd12: u = '{OP_ADD, R_BIAS, R_T0, R_BIAS};
         5'd13: u = '{OP_SUB, R_ONE, R_K0, R_OMK};
         5'd14: u = '{OP_SUB, R_K0, R_ONE, R_KMO};
         5'd15: u = '{OP_MUL, R_CAA, R_OMK, R_N00};
         5'd16: u = '{OP_MUL, R_CAB, R_DT, R_T0};
         5'd17: u = '{OP_MUL, R_T0, R_KMO, R_T0};
         5'd18: u = '{OP_ADD, R_N00, R_T0, R_N00};
         5'd19: u = '{OP_MUL, R_CBA, R_DT, R_T0};
         5'd20: u = '{OP_SUB, R_N00, R_T0, R_N00};
         5'd21: u = '{OP_MUL, R_CBB, R_DT, R_T0};
         5'd22: u = '{OP_MUL, R_T0, R_DT, R_T0};
         5'd23: u = '{OP_ADD, R_N00, R_T0, R_N00};
         5'd24: u = '{OP_MUL, R_CAB, R_OMK, R_T1};
         5'd25: u = '{OP_MUL, R_DT, R_CBB, R_T2};
         5'd26: u = '{OP_SUB, R_T1, R_T2, R_N01};
         5'd27: u = '{OP_MUL, R_K1, R_CAB, R_T1};
         5'd28: u = '{OP_SUB, R_T1, R_CBB, R_T1};
         5'd29: u = '{OP_MUL, R_DT, R_T1, R_T1};
         5'd30: u = '{OP_ADD, R_CBA, R_T1, R_N10};
         default: u = '{OP_NONE, R_ZERO, R_ZERO, R_ZERO};
      endcase
      return u;
   endfunction

   // Second half of the program, kept apart to stay within 5 bits.
   function automatic uop_type uop_rom2(input logic [4:0] pc);
      uop_type u;
      u = '{OP_NONE, R_ZERO, R_ZERO, R_ZERO};
      case (pc)
         5'd0: u = '{OP_MUL, R_K1, R_CAA, R_T1};
         5'd1: u = '{OP_SUB, R_N10, R_T1, R_N10};
         5'd2: u = '{OP_MUL, R_K1, R_CAB, R_T1};
         5'd3: u = '{OP_SUB, R_CBB, R_T1, R_N11};
         5'd4: u = '{OP_ADD, R_N00, R_QA, R_N00};
         5'd5: u = '{OP_ADD, R_N11, R_QB, R_N11};
         default: u = '{OP_NONE, R_ZERO, R_ZERO, R_ZERO};
      endcase
      return u;
   endfunction

   localparam logic [5:0] PROG_LEN = 6'd37;

   function automatic logic signed [31:0] sat64(input logic signed [65:0] v);
      if (v > 66'(SAT_MAX)) return SAT_MAX;
      if (v < 66'(SAT_MIN)) return SAT_MIN;
      return v[31:0];
   endfunction

endpackage

// ===== rtl/gakts_div.sv =====
// Restoring divider for the gain quotient, one quotient bit per cycle.
module gakts_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  num,
   input  logic signed [31:0]  den,
   output logic                done,
   output logic signed [31:0]  quot
);
   import gakts_pkg::*;

   logic [47:0] rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic [30:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [48:0] trial;
   logic [32:0] nabs;
   logic [47:0] mag;
   logic signed [65:0] sq;

   // Dividend is |num| * 2^16 (at most 48 bits); den is positive here.
   always_comb begin
      nabs = num[31] ? -{num[31], num} : {num[31], num};
      mag = {nabs[31:0], 16'd0};
      rem_in = rem_ff; q_in = q_ff; den_in = den_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; run_in = run_ff; done_in = 1'b0;
      trial = {rem_ff, q_ff[47]} - {18'd0, den_ff};
      if (start) begin
         rem_in = '0; q_in = mag; den_in = den[30:0]; neg_in = num[31];
         cnt_in = 6'd48; run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[48]) rem_in = trial[47:0];
         else rem_in = {rem_ff[46:0], q_ff[47]};
         q_in = {q_ff[46:0], ~trial[48]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         run_ff <= run_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; den_ff <= den_in; neg_ff <= neg_in;
   end

   assign sq = neg_ff ? -66'($unsigned(q_ff)) : 66'($unsigned(q_ff));
   assign quot = sat64(sq);
   assign done = done_ff;
endmodule

// ===== rtl/gakts_datapath.sv =====
// Register file, multiplier, saturating adder and divider of the filter.
module gakts_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  gakts_pkg::cmd_type         cmd,
   output gakts_pkg::sts_type         sts,
   input  logic signed [31:0]         in_rate,
   input  logic signed [31:0]         in_meas,
   input  logic [15:0]                in_dt,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_sel,
   input  logic [30:0]                csr_val,
   output logic signed [31:0]         angle_out,
   output logic signed [31:0]         bias_out
);
   import gakts_pkg::*;

   logic signed [31:0] rf_ff [27];
   logic signed [31:0] a, b, res;
   logic signed [63:0] prod_ff;
   logic               mul_pend_ff;
   reg_type            dst_ff;
   logic signed [63:0] p;
   logic signed [47:0] pq;
   logic               div_done;
   logic signed [31:0] quot;
   logic               u_div_busy;
   logic               div_run_ff;

   assign a = rf_ff[cmd.uop.src_a];
   assign b = rf_ff[cmd.uop.src_b];
   assign p = prod_ff;
   // Arithmetic shift floors, as required for negative products.
   assign pq = p[63:16];

   gakts_div u_div (
      .clock(clock), .reset(reset),
      .start(cmd.start && cmd.uop.op == OP_DIV && !cmd.skip_k),
      .num(a), .den(b), .done(div_done), .quot(quot)
   );

   always_comb begin
      res = '0;
      case (cmd.uop.op)
         OP_ADD:  res = sat64(66'(a) + 66'(b));
         OP_SUB:  res = sat64(66'(a) - 66'(b));
         default: res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ff[R_ANGLE] <= '0; rf_ff[R_BIAS] <= '0;
         rf_ff[R_CAA] <= ONE_Q16; rf_ff[R_CAB] <= '0;
         rf_ff[R_CBA] <= '0; rf_ff[R_CBB] <= ONE_Q16;
         rf_ff[R_RN] <= 32'sd19661; rf_ff[R_QA] <= 32'sd66; rf_ff[R_QB] <= 32'sd197;
         rf_ff[R_ONE] <= ONE_Q16; rf_ff[R_ZERO] <= '0;
         mul_pend_ff <= 1'b0;
      end else begin
         mul_pend_ff <= cmd.start && (cmd.uop.op == OP_MUL);
         if (csr_we) begin
            case (csr_sel)
               REG_MEAS_NOISE:  rf_ff[R_RN] <= {1'b0, csr_val};
               REG_ANGLE_NOISE: rf_ff[R_QA] <= {1'b0, csr_val};
               REG_BIAS_NOISE:  rf_ff[R_QB] <= {1'b0, csr_val};
               default: ;
            endcase
         end
         if (cmd.load_in) begin
            rf_ff[R_RATE] <= in_rate; rf_ff[R_MEAS] <= in_meas;
            rf_ff[R_DT] <= {16'd0, in_dt};
         end
         if (cmd.start) begin
            dst_ff <= cmd.uop.dst;
            case (cmd.uop.op)
               OP_MUL: prod_ff <= a * b;
               OP_ADD, OP_SUB: rf_ff[cmd.uop.dst] <= res;
               OP_DIV: if (cmd.skip_k) rf_ff[cmd.uop.dst] <= '0;
               default: ;
            endcase
         end
         if (mul_pend_ff) rf_ff[dst_ff] <= sat64(66'(pq));
         if (div_done) rf_ff[dst_ff] <= quot;
         if (cmd.commit) begin
            rf_ff[R_CAA] <= rf_ff[R_N00]; rf_ff[R_CAB] <= rf_ff[R_N01];
            rf_ff[R_CBA] <= rf_ff[R_N10]; rf_ff[R_CBB] <= rf_ff[R_N11];
         end
      end
   end

   assign sts.busy = u_div_busy;
   always_ff @(posedge clock) begin
      if (reset) div_run_ff <= 1'b0;
      else if (cmd.start && cmd.uop.op == OP_DIV && !cmd.skip_k) div_run_ff <= 1'b1;
      else if (div_done) div_run_ff <= 1'b0;
   end
   assign u_div_busy = div_run_ff || mul_pend_ff;
   assign sts.cov_pos = !rf_ff[R_COV][31] && (rf_ff[R_COV] != 32'sd0);
   assign angle_out = rf_ff[R_ANGLE];
   assign bias_out = rf_ff[R_BIAS];
endmodule

// ===== rtl/gakts_ctrl.sv =====
// Sequencer that steps the datapath through the filter program.
module gakts_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output gakts_pkg::cmd_type cmd,
   input  gakts_pkg::sts_type sts,
   output logic               out_load
);
   import gakts_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_RUN = 4'b0010, S_WAIT = 4'b0100, S_DONE = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] pc_ff, pc_in;
   logic       rv_ff, rv_in;
   uop_type    u;

   always_comb begin
      u = (pc_ff < 6'd31) ? uop_rom(pc_ff[4:0]) : uop_rom2(5'(pc_ff - 6'd31));
      state_in = state_ff; pc_in = pc_ff; rv_in = rv_ff;
      cmd = '{1'b0, u, 1'b0, 1'b0, !sts.cov_pos};
      out_load = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load_in = 1'b1; pc_in = '0; state_in = S_RUN;
         end
         S_RUN: begin
            cmd.start = 1'b1; state_in = S_WAIT;
         end
         S_WAIT: if (!sts.busy) begin
            if (pc_ff == PROG_LEN - 6'd1) state_in = S_DONE;
            else begin
               pc_in = pc_ff + 6'd1; state_in = S_RUN;
            end
         end
         S_DONE: if (!rv_ff || rsp_ready) begin
            cmd.commit = 1'b1; out_load = 1'b1; rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; pc_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pc_ff <= pc_in; rv_ff <= rv_in;
      end
   end
endmodule

// ===== rtl/gyro_accel_kalman_two_state.sv =====
// Top level of the two-state angle and gyro-bias filter.
// Usage:
//   A word on the req_ channel carries gyro rate, accelerometer angle and
//   time step; each accepted word yields one rsp_ word holding the corrected
//   angle and bias estimates. csr_ writes set the measurement noise (index
//   0), angle process noise (1) and bias process noise (2); other indexes
//   are ignored. Write them only while the block is idle.
//   The program runs 37 micro-operations: adds, subtracts, 16 multiplies
//   and two gain divisions. A division is started, the divider develops
//   its 48-bit quotient, the quotient is written back, and the sequencer
//   then sees the divider idle. After the last micro-operation a commit
//   copies the new covariances into the state and loads the result. When
//   the covariance is not positive, both divisions are skipped and the
//   gains are zeroed. One word is processed at a time; a new word is
//   accepted only once the block is idle again. The result sits in an
//   output register; the next word is accepted while it waits, and a
//   stalled receiver only holds back the commit of the following result.
//   Synchronous reset restores the filter state (angle and bias zero,
//   diagonal covariances one) and the register defaults.
module gyro_accel_kalman_two_state (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_gyro_rate,
   input  logic signed [31:0] req_measured_angle,
   input  logic [15:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_angle_estimate,
   output logic signed [31:0] rsp_bias_estimate,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_data
);
   import gakts_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    out_load;
   logic signed [31:0] ang, bia;
   logic signed [31:0] ang_ff, bia_ff;

   assign csr_ready = 1'b1;

   gakts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .sts(sts),
      .out_load(out_load)
   );

   gakts_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_rate(req_gyro_rate), .in_meas(req_measured_angle), .in_dt(req_time_step),
      .csr_we(csr_valid), .csr_sel(csr_index), .csr_val(csr_data),
      .angle_out(ang), .bias_out(bia)
   );

   always_ff @(posedge clock) begin
      if (out_load) begin
         ang_ff <= ang; bia_ff <= bia;
      end
   end

   assign rsp_angle_estimate = ang_ff;
   assign rsp_bias_estimate = bia_ff;
endmodule

// ===== tb/gyro_accel_kalman_two_state_checker.sv =====
// Checker that predicts the filter estimates and compares every response word.
`timescale 1ns / 100ps

module gyro_accel_kalman_two_state_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_gyro_rate,
   input  logic signed [31:0] req_measured_angle,
   input  logic [15:0]        req_time_step,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_angle_estimate,
   input  logic signed [31:0] rsp_bias_estimate,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_data,
   output int                 errors,
   output int                 pending
);
   import gakts_pkg::*;

   typedef struct {
      int angle;
      int bias;
   } estimate_type;

   estimate_type estimate_q[$];

   int meas_noise, angle_noise, bias_noise;
   int angle, bias, cov_aa, cov_ab, cov_ba, cov_bb;

   function automatic int sat(input longint v);
      if (v > longint'(SAT_MAX)) return SAT_MAX;
      if (v < longint'(SAT_MIN)) return SAT_MIN;
      return int'(v);
   endfunction

   function automatic int add_q(input int a, input int b);
      return sat(longint'(a) + longint'(b));
   endfunction

   function automatic int sub_q(input int a, input int b);
      return sat(longint'(a) - longint'(b));
   endfunction

   // The arithmetic shift of a signed product rounds toward minus infinity.
   function automatic int mul_q(input int a, input int b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat(p >>> 16);
   endfunction

   function automatic int div_q(input int num, input int den);
      longint n;
      n = longint'(num) * 64'sd65536;
      return sat(n / longint'(den));
   endfunction

   task automatic filter_step(input int rate, input int meas, input int dt,
                              output estimate_type est);
      int innov, cov, k0, k1, omk, kmo, n00, n01, n10, n11;
      k0 = 0;
      k1 = 0;
      angle = add_q(angle, mul_q(dt, sub_q(rate, bias)));
      innov = sub_q(meas, angle);
      cov = add_q(cov_aa, meas_noise);
      // A covariance that is not positive leaves both gains at zero.
      if (cov > 0) begin
         k0 = div_q(sub_q(cov_aa, mul_q(dt, cov_ba)), cov);
         k1 = div_q(cov_ba, cov);
      end
      angle = add_q(angle, mul_q(k0, innov));
      bias = add_q(bias, mul_q(k1, innov));
      omk = sub_q(ONE_Q16, k0);
      kmo = sub_q(k0, ONE_Q16);
      n00 = mul_q(cov_aa, omk);
      n00 = add_q(n00, mul_q(mul_q(cov_ab, dt), kmo));
      n00 = sub_q(n00, mul_q(cov_ba, dt));
      n00 = add_q(n00, mul_q(mul_q(cov_bb, dt), dt));
      n01 = sub_q(mul_q(cov_ab, omk), mul_q(dt, cov_bb));
      n10 = add_q(cov_ba, mul_q(dt, sub_q(mul_q(k1, cov_ab), cov_bb)));
      n10 = sub_q(n10, mul_q(k1, cov_aa));
      n11 = sub_q(cov_bb, mul_q(k1, cov_ab));
      cov_aa = add_q(n00, angle_noise);
      cov_ab = n01;
      cov_ba = n10;
      cov_bb = add_q(n11, bias_noise);
      est.angle = angle;
      est.bias = bias;
   endtask

   always @(posedge clock) begin
      estimate_type est;
      if (reset) begin
         meas_noise = 19661;
         angle_noise = 66;
         bias_noise = 197;
         angle = 0;
         bias = 0;
         cov_aa = ONE_Q16;
         cov_ab = 0;
         cov_ba = 0;
         cov_bb = ONE_Q16;
         estimate_q.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MEAS_NOISE:  meas_noise = int'({1'b0, csr_data});
               REG_ANGLE_NOISE: angle_noise = int'({1'b0, csr_data});
               REG_BIAS_NOISE:  bias_noise = int'({1'b0, csr_data});
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            filter_step(req_gyro_rate, req_measured_angle, int'({16'd0, req_time_step}), est);
            estimate_q.push_back(est);
         end
         if (rsp_valid && rsp_ready) begin
            if (estimate_q.size() == 0) begin
               $error("unexpected response word: angle %0d bias %0d",
                      rsp_angle_estimate, rsp_bias_estimate);
               errors = errors + 1;
            end else begin
               est = estimate_q.pop_front();
               if (rsp_angle_estimate !== est.angle) begin
                  $error("angle_estimate expected %0d actual %0d", est.angle,
                         rsp_angle_estimate);
                  errors = errors + 1;
               end
               if (rsp_bias_estimate !== est.bias) begin
                  $error("bias_estimate expected %0d actual %0d", est.bias,
                         rsp_bias_estimate);
                  errors = errors + 1;
               end
            end
         end
      end
      pending <= estimate_q.size();
   end

endmodule

// ===== tb/gyro_accel_kalman_two_state_test.sv =====
// Top of the filter testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module gyro_accel_kalman_two_state_test;
   import gakts_pkg::*;

   localparam int DRAIN_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_gyro_rate;
   logic signed [31:0] req_measured_angle;
   logic [15:0]        req_time_step;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_angle_estimate;
   logic signed [31:0] rsp_bias_estimate;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [30:0]        csr_data;

   int errors, pending;
   int send_idle_pct, recv_idle_pct;
   int stall_cycles;
   bit hold_request, hold_done;

   gyro_accel_kalman_two_state DUT (.*);

   gyro_accel_kalman_two_state_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random idling, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("gyro_accel_kalman_two_state_test NOT OK");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
         2: return 32'($signed($urandom_range(400 << 16)) - (200 << 16));
         3: case ($urandom_range(3))
               0: return SAT_MAX;
               1: return SAT_MIN;
               2: return 32'd0;
               default: return 32'hffffffff;
            endcase
         default: return 32'($signed($urandom_range(1 << 16)) - (1 << 15));
      endcase
   endfunction

   function automatic logic [15:0] pick_step();
      if ($urandom_range(9) < 7) return 16'($urandom_range(2000));
      return 16'($urandom);
   endfunction

   task automatic send_word(input logic [31:0] rate, input logic [31:0] meas,
                            input logic [15:0] dt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_gyro_rate <= rate;
      req_measured_angle <= meas;
      req_time_step <= dt;
      @(posedge clock iff (req_valid && req_ready));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [30:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock iff (csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_word(pick_value(), pick_value(), pick_step());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_gyro_rate = '0;
      req_measured_angle = '0;
      req_time_step = '0;
      csr_valid = 1'b0;
      csr_index = REG_MEAS_NOISE;
      csr_data = '0;
      send_idle_pct = 20;
      recv_idle_pct = 80;
      hold_request = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at the field extremes, with the reset noise values.
      send_word(32'd0, 32'd0, 16'd0);
      send_word(SAT_MAX, SAT_MAX, 16'hffff);
      send_word(SAT_MIN, SAT_MIN, 16'hffff);
      send_word(SAT_MAX, SAT_MIN, 16'd1);
      send_word(SAT_MIN, SAT_MAX, 16'd0);
      send_word(32'hffffffff, 32'd1, 16'hffff);
      send_word(32'h55555555, 32'haaaaaaaa, 16'h5555);
      send_word(32'haaaaaaaa, 32'h55555555, 16'haaaa);
      send_word(ONE_Q16, ONE_Q16, 16'd655);
      send_word(SAT_MAX, 32'd0, 16'hffff);
      send_word(SAT_MIN, 32'd0, 16'hffff);
      send_word(32'd0, SAT_MAX, 16'h8000);
      drain();

      // Smallest noises; zero measurement noise is taken as written.
      write_reg(REG_MEAS_NOISE, 31'd0);
      write_reg(REG_ANGLE_NOISE, 31'd0);
      write_reg(REG_BIAS_NOISE, 31'd0);
      send_word(SAT_MAX, SAT_MIN, 16'hffff);
      send_word(SAT_MIN, SAT_MAX, 16'hffff);
      send_word(32'd0, SAT_MAX, 16'hffff);
      send_word(32'd0, 32'd0, 16'd1);
      drain();

      write_reg(REG_MEAS_NOISE, 31'd1);
      write_reg(REG_ANGLE_NOISE, 31'($urandom_range(1000)));
      write_reg(REG_BIAS_NOISE, 31'($urandom_range(1000)));
      send_idle_pct = 20;
      recv_idle_pct = 80;
      send_random(650);
      drain();

      // Largest noises, and a write to the unused index that must be ignored.
      write_reg(REG_MEAS_NOISE, 31'h7fffffff);
      write_reg(REG_ANGLE_NOISE, 31'h7fffffff);
      write_reg(REG_BIAS_NOISE, 31'h7fffffff);
      write_reg(REG_UNUSED, 31'($urandom));
      send_idle_pct = 80;
      recv_idle_pct = 20;
      send_random(100);
      hold_request = 1'b1;
      send_random(500);
      drain();

      write_reg(REG_MEAS_NOISE, 31'($urandom));
      write_reg(REG_ANGLE_NOISE, 31'($urandom_range(5000)));
      write_reg(REG_BIAS_NOISE, 31'($urandom));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(650);
      drain();

      if (errors == 0)
         $display("gyro_accel_kalman_two_state_test OK");
      else
         $display("gyro_accel_kalman_two_state_test NOT OK");
      $finish;
   end

endmodule
